FILE: src/lowest_request_arbiter_assert.svh
// Assertion helpers shared by the arbiter RTL.
`ifndef LOWEST_REQUEST_ARBITER_ASSERT_SVH
`define LOWEST_REQUEST_ARBITER_ASSERT_SVH

// Property that must hold in every cycle outside reset.
`define LRA_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lra_pkg.sv
package lra_pkg;

    // Number of requesting policies, one cell each
    localparam int POLICY_COUNT = 16;

    // Fixed field widths
    localparam int POLICY_IDX_W = 4;
    localparam int VOLT_W       = 32;
    localparam int OFFSET_W     = 16;

    // Cell index width: wide enough for the cell count and the policy field
    localparam int CELL_IDX_W = ($clog2(POLICY_COUNT) > POLICY_IDX_W) ?
                                $clog2(POLICY_COUNT) : POLICY_IDX_W;
    localparam int CNT_W      = $clog2(POLICY_COUNT);

    // Operation codes
    localparam logic [1:0] MODE_PREVIEW = 2'd0;
    localparam logic [1:0] MODE_COMMIT  = 2'd1;
    localparam logic [1:0] MODE_REMOVE  = 2'd2;

    // Table select
    localparam logic TBL_VOLT   = 1'b0;
    localparam logic TBL_OFFSET = 1'b1;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [VOLT_W-1:0] value;
    } t_best;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                  wr_en;
        logic                  sub_en;
        logic                  tbl;
        logic [CELL_IDX_W-1:0] idx;
        logic [VOLT_W-1:0]     value;
        logic                  ok;
    } t_cell_ctl;

endpackage

FILE: src/lra_if.sv
// Request channel
interface lra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        target;
    logic [3:0]  policy_index;
    logic [31:0] request_value;
    logic        request_valid;

    modport source (
        output valid, mode, target, policy_index, request_value, request_valid,
        input  ready
    );
    modport sink (
        input  valid, mode, target, policy_index, request_value, request_valid,
        output ready
    );
endinterface

// Result channel
interface lra_res_if;
    logic        valid;
    logic        ready;
    logic        winner_valid;
    logic [31:0] winner_value;
    logic        winner_changed;

    modport source (
        output valid, winner_valid, winner_value, winner_changed,
        input  ready
    );
    modport sink (
        input  valid, winner_valid, winner_value, winner_changed,
        output ready
    );
endinterface

FILE: src/lra_cell.sv
module lra_cell
    import lra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CELL_IDX_W-1:0] i_cell_idx,
    input  t_cell_ctl             i_ctl,
    input  t_best                 i_best,
    output t_best                 o_best,
    output logic                  o_hit_present
);

    logic [VOLT_W-1:0]   r_volt;
    logic [OFFSET_W-1:0] r_off;
    logic                r_v_valid;
    logic                r_v_present;
    logic                r_o_valid;
    logic                r_o_present;
    t_best               r_best;

    logic                w_sel;
    logic                w_sub;
    logic [VOLT_W-1:0]   w_own_value;
    logic                w_own_ok;
    t_best               n_best;

    assign w_sel = (i_ctl.idx == i_cell_idx);
    assign w_sub = i_ctl.sub_en && w_sel;

    // Presence of this entry in the chosen table, when addressed
    assign o_hit_present = w_sel &&
                           ((i_ctl.tbl == TBL_OFFSET) ? r_o_present : r_v_present);

    // Own entry, or the previewed stand-in
    always_comb begin
        if (w_sub) begin
            w_own_value = i_ctl.value;
            w_own_ok    = i_ctl.ok;
        end else if (i_ctl.tbl == TBL_OFFSET) begin
            w_own_value = {{(VOLT_W-OFFSET_W){1'b0}}, r_off};
            w_own_ok    = r_o_valid;
        end else begin
            w_own_value = r_volt;
            w_own_ok    = r_v_valid;
        end
    end

    // Keep the lower of the incoming minimum and this entry
    always_comb begin
        if (w_own_ok && (!i_best.valid || (w_own_value < i_best.value))) begin
            n_best.valid = 1'b1;
            n_best.value = w_own_value;
        end else begin
            n_best = i_best;
        end
    end

    // Entry storage and chain stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid   <= 1'b0;
            r_v_present <= 1'b0;
            r_o_valid   <= 1'b0;
            r_o_present <= 1'b0;
        end else if (i_ctl.wr_en && w_sel) begin
            if (i_ctl.tbl == TBL_OFFSET) begin
                r_o_valid   <= i_ctl.ok;
                r_o_present <= 1'b1;
            end else begin
                r_v_valid   <= i_ctl.ok;
                r_v_present <= 1'b1;
            end
        end
        if (i_ctl.wr_en && w_sel) begin
            if (i_ctl.tbl == TBL_OFFSET) begin
                r_off <= i_ctl.value[OFFSET_W-1:0];
            end else begin
                r_volt <= i_ctl.value;
            end
        end
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

FILE: src/lowest_request_arbiter.sv
// Channel   Dir  Fields                                                   Transfer
// i_req     in   mode, target, policy_index, request_value, request_valid valid & ready
// o_res     out  winner_valid, winner_value, winner_changed               valid & ready
//
// Each item passes through accept, entry write, a scan along the POLICY_COUNT cells and
// result load before the next input can be taken. The running minimum moves one cell per
// cycle, so the chain length sets the length of the scan.
// i_rst_n is synchronous; it clears all marks, both winners and both flags.
// A new item is taken while a result waits; its result load stalls while that one is held.
module lowest_request_arbiter
    import lra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    lra_req_if.sink  i_req,
    lra_res_if.source o_res
);

    `include "lowest_request_arbiter_assert.svh"

    typedef enum logic [1:0] {S_IDLE, S_WRITE, S_SCAN, S_DONE} t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // Latched item
    logic                  r_commit, n_commit;
    logic                  r_remove, n_remove;
    logic                  r_tbl, n_tbl;
    logic [CELL_IDX_W-1:0] r_idx, n_idx;
    logic [VOLT_W-1:0]     r_value, n_value;
    logic                  r_ok, n_ok;
    logic                  r_in_range, n_in_range;

    // Stored winners and changed flags
    logic                  r_vwin_valid, n_vwin_valid;
    logic [VOLT_W-1:0]     r_vwin_value, n_vwin_value;
    logic                  r_owin_valid, n_owin_valid;
    logic [OFFSET_W-1:0]   r_owin_value, n_owin_value;
    logic [1:0]            r_chg, n_chg;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_wvalid, n_out_wvalid;
    logic [VOLT_W-1:0]     r_out_value, n_out_value;
    logic                  r_out_changed, n_out_changed;

    t_cell_ctl             w_ctl;
    t_best                 w_chain [POLICY_COUNT+1];
    logic [POLICY_COUNT-1:0] w_hit;
    logic                  w_present;
    logic [CELL_IDX_W-1:0] w_in_idx;

    // Terms used by the checks
    logic                  w_in_xfer;
    logic                  w_done_stall;
    logic                  w_scan;

    // Cell row
    assign w_chain[0] = '0;

    for (genvar g = 0; g < POLICY_COUNT; g++) begin : g_cell
        lra_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cell_idx    (CELL_IDX_W'(g)),
            .i_ctl         (w_ctl),
            .i_best        (w_chain[g]),
            .o_best        (w_chain[g+1]),
            .o_hit_present (w_hit[g])
        );
    end

    assign w_present = |w_hit;

    // Control to the cells
    always_comb begin
        w_ctl.wr_en  = (r_state == S_WRITE) && r_in_range &&
                       (r_commit || (r_remove && w_present));
        w_ctl.sub_en = !r_commit && !r_remove && r_in_range;
        w_ctl.tbl    = r_tbl;
        w_ctl.idx    = r_idx;
        w_ctl.value  = r_remove ? '0 : r_value;
        w_ctl.ok     = r_remove ? 1'b0 : r_ok;
    end

    assign w_in_idx = CELL_IDX_W'(i_req.policy_index);

    // Sequencer next state
    always_comb begin
        logic [VOLT_W:0] v_old;
        logic [VOLT_W:0] v_now;
        logic            v_diff;
        logic            v_flag;

        n_state       = r_state;
        n_cnt         = r_cnt;
        n_commit      = r_commit;
        n_remove      = r_remove;
        n_tbl         = r_tbl;
        n_idx         = r_idx;
        n_value       = r_value;
        n_ok          = r_ok;
        n_in_range    = r_in_range;
        n_vwin_valid  = r_vwin_valid;
        n_vwin_value  = r_vwin_value;
        n_owin_valid  = r_owin_valid;
        n_owin_value  = r_owin_value;
        n_chg         = r_chg;
        n_out_valid   = r_out_valid;
        n_out_wvalid  = r_out_wvalid;
        n_out_value   = r_out_value;
        n_out_changed = r_out_changed;

        v_old = (r_tbl == TBL_OFFSET) ?
                {r_owin_valid, {(VOLT_W-OFFSET_W){1'b0}}, r_owin_value} :
                {r_vwin_valid, r_vwin_value};
        v_now  = {w_chain[POLICY_COUNT].valid, w_chain[POLICY_COUNT].value};
        v_diff = (v_old != v_now);
        v_flag = r_chg[r_tbl];

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_commit   = (i_req.mode == MODE_COMMIT);
                    n_remove   = (i_req.mode == MODE_REMOVE);
                    n_tbl      = i_req.target;
                    n_idx      = w_in_idx;
                    n_value    = (i_req.target == TBL_OFFSET) ?
                                 {{(VOLT_W-OFFSET_W){1'b0}},
                                  i_req.request_value[OFFSET_W-1:0]} :
                                 i_req.request_value;
                    n_ok       = i_req.request_valid;
                    n_in_range = ({1'b0, w_in_idx} < (CELL_IDX_W+1)'(POLICY_COUNT));
                    n_state    = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(POLICY_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    priority if ((r_commit || r_remove) && !r_in_range) begin
                        n_out_wvalid = v_old[VOLT_W];
                        n_out_value  = v_old[VOLT_W-1:0];
                    end else if (r_remove && !w_present) begin
                        v_flag       = 1'b0;
                        n_out_wvalid = v_old[VOLT_W];
                        n_out_value  = v_old[VOLT_W-1:0];
                    end else if (r_commit || r_remove) begin
                        v_flag = (r_remove && (r_tbl == TBL_OFFSET)) ?
                                 (v_now[VOLT_W] && v_diff) : v_diff;
                        if (r_tbl == TBL_OFFSET) begin
                            n_owin_valid = v_now[VOLT_W];
                            n_owin_value = v_now[OFFSET_W-1:0];
                        end else begin
                            n_vwin_valid = v_now[VOLT_W];
                            n_vwin_value = v_now[VOLT_W-1:0];
                        end
                        n_out_wvalid = v_now[VOLT_W];
                        n_out_value  = v_now[VOLT_W-1:0];
                    end else begin
                        n_out_wvalid = v_now[VOLT_W];
                        n_out_value  = v_now[VOLT_W-1:0];
                    end
                    n_chg[r_tbl]  = v_flag;
                    n_out_changed = v_flag;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, stored winners and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_vwin_valid <= 1'b0;
            r_vwin_value <= '0;
            r_owin_valid <= 1'b0;
            r_owin_value <= '0;
            r_chg        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_vwin_valid <= n_vwin_valid;
            r_vwin_value <= n_vwin_value;
            r_owin_valid <= n_owin_valid;
            r_owin_value <= n_owin_value;
            r_chg        <= n_chg;
            r_out_valid  <= n_out_valid;
        end
        r_commit      <= n_commit;
        r_remove      <= n_remove;
        r_tbl         <= n_tbl;
        r_idx         <= n_idx;
        r_value       <= n_value;
        r_ok          <= n_ok;
        r_in_range    <= n_in_range;
        r_out_wvalid  <= n_out_wvalid;
        r_out_value   <= n_out_value;
        r_out_changed <= n_out_changed;
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.winner_valid   = r_out_wvalid;
    assign o_res.winner_value   = r_out_value;
    assign o_res.winner_changed = r_out_changed;

    assign w_in_xfer    = i_req.valid && i_req.ready;
    assign w_done_stall = (r_state == S_DONE) && r_out_valid && !o_res.ready;
    assign w_scan       = (r_state == S_SCAN);

    // Checks
    `LRA_ASSERT_NEXT(a_busy, i_clk, i_rst_n, w_in_xfer, !i_req.ready, "ready after transfer")
    `LRA_ASSERT_ALWAYS(a_cnt_idle, i_clk, i_rst_n, w_scan || (r_cnt == '0), "count outside scan")
    `LRA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_done_stall, r_state == S_DONE, "result lost")
    `LRA_ASSERT_ALWAYS(a_vwin, i_clk, i_rst_n, r_vwin_valid || ~|r_vwin_value, "voltage winner")
    `LRA_ASSERT_ALWAYS(a_owin, i_clk, i_rst_n, r_owin_valid || ~|r_owin_value, "offset winner")

endmodule

FILE: bench/lowest_request_arbiter_tb.sv
module lowest_request_arbiter_tb
    import lra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Mode 3 is not decoded by the block and falls back to a preview
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int ITEM_LATENCY = POLICY_COUNT + 3;
    localparam int RANDOM_ITEMS = 450;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]  mode;
        logic        target;
        logic [3:0]  idx;
        logic [31:0] value;
        logic        ok;
    } t_req_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        logic        changed;
    } t_winner;

    typedef struct packed {
        t_req_item item;
        logic      has_exp;
        t_winner   exp;
    } t_stim_row;

    localparam int STIM_ROWS = 23;

    // Directed rows; expected result typed in where it is obvious
    localparam t_stim_row STIM_TABLE [STIM_ROWS] = '{
        // nothing valid right after reset
        '{'{MODE_PREVIEW, TBL_VOLT,   4'd0,  32'h0000_0000, 1'b0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        // remove of an absent entry on an empty table
        '{'{MODE_REMOVE,  TBL_VOLT,   4'd3,  32'h0000_0000, 1'b1}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        // extremes of the voltage table
        '{'{MODE_COMMIT,  TBL_VOLT,   4'd0,  32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b1}},
        '{'{MODE_COMMIT,  TBL_VOLT,   4'd15, 32'h0000_0000, 1'b1}, 1'b1, '{1'b1, 32'h0, 1'b1}},
        '{'{MODE_PREVIEW, TBL_VOLT,   4'd15, 32'h0000_0005, 1'b1}, 1'b0, '0},
        // offset table keeps the low half only
        '{'{MODE_COMMIT,  TBL_OFFSET, 4'd15, 32'hFFFF_1234, 1'b1}, 1'b1,
          '{1'b1, 32'h0000_1234, 1'b1}},
        '{'{MODE_COMMIT,  TBL_OFFSET, 4'd0,  32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{MODE_COMMIT,  TBL_OFFSET, 4'd0,  32'h0001_FFFF, 1'b1}, 1'b0, '0},
        '{'{MODE_REMOVE,  TBL_OFFSET, 4'd15, 32'h0000_0000, 1'b0}, 1'b0, '0},
        // offset flag stays low when the new winner is invalid
        '{'{MODE_REMOVE,  TBL_OFFSET, 4'd0,  32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
        '{'{MODE_COMMIT,  TBL_OFFSET, 4'd3,  32'h0000_0007, 1'b1}, 1'b0, '0},
        // absent remove clears the flag
        '{'{MODE_REMOVE,  TBL_OFFSET, 4'd9,  32'h0000_0000, 1'b0}, 1'b0, '0},
        // equal values in two entries
        '{'{MODE_COMMIT,  TBL_VOLT,   4'd7,  32'h0000_0000, 1'b1}, 1'b0, '0},
        '{'{MODE_REMOVE,  TBL_VOLT,   4'd15, 32'h0000_0000, 1'b1}, 1'b0, '0},
        '{'{MODE_REMOVE,  TBL_VOLT,   4'd7,  32'h0000_0000, 1'b1}, 1'b0, '0},
        // undecoded mode acts as a preview
        '{'{MODE_UNUSED,  TBL_VOLT,   4'd0,  32'hAAAA_5555, 1'b0}, 1'b0, '0},
        '{'{MODE_UNUSED,  TBL_OFFSET, 4'd3,  32'h0001_0005, 1'b1}, 1'b0, '0},
        // voltage flag is set even when the winner goes invalid
        '{'{MODE_REMOVE,  TBL_VOLT,   4'd0,  32'h5555_AAAA, 1'b0}, 1'b0, '0},
        '{'{MODE_REMOVE,  TBL_VOLT,   4'd0,  32'h0000_0000, 1'b0}, 1'b0, '0},
        // same commit twice leaves the flag low
        '{'{MODE_COMMIT,  TBL_VOLT,   4'd1,  32'h5555_AAAA, 1'b1}, 1'b0, '0},
        '{'{MODE_COMMIT,  TBL_VOLT,   4'd1,  32'h5555_AAAA, 1'b1}, 1'b0, '0},
        '{'{MODE_PREVIEW, TBL_OFFSET, 4'd15, 32'h0000_FFFF, 1'b0}, 1'b0, '0},
        '{'{MODE_COMMIT,  TBL_OFFSET, 4'd8,  32'h0000_0000, 1'b1}, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    lra_req_if req_if ();
    lra_res_if res_if ();

    lowest_request_arbiter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Shadow copy of both request tables
    logic [31:0] entry_value   [2][POLICY_COUNT];
    logic        entry_ok      [2][POLICY_COUNT];
    logic        entry_present [2][POLICY_COUNT];
    t_best       stored_best   [2];
    logic [1:0]  changed_flag;

    t_winner pending_winners [$];
    int      error_count;
    int      mismatch_count;
    int      burst_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic clear_tables();
        int t;
        int i;
        for (t = 0; t < 2; t++) begin
            for (i = 0; i < POLICY_COUNT; i++) begin
                entry_value[t][i]   = '0;
                entry_ok[t][i]      = 1'b0;
                entry_present[t][i] = 1'b0;
            end
            stored_best[t] = '0;
        end
        changed_flag = '0;
    endtask

    // Lowest valid value of a table, optionally with one entry replaced
    function automatic t_best lowest_valid(input logic tbl, input logic use_sub,
                                           input int sub_idx, input logic [31:0] sub_value,
                                           input logic sub_ok);
        t_best       best;
        logic [31:0] v;
        logic        ok;
        int          i;
        best = '0;
        for (i = 0; i < POLICY_COUNT; i++) begin
            if (use_sub && i == sub_idx) begin
                v  = sub_value;
                ok = sub_ok;
            end else begin
                v  = entry_value[tbl][i];
                ok = entry_ok[tbl][i];
            end
            if (ok && (!best.valid || v < best.value)) begin
                best.valid = 1'b1;
                best.value = v;
            end
        end
        return best;
    endfunction

    // Apply one request to the shadow tables and return the winner it reports
    function automatic t_winner arbitrate_item(input t_req_item item);
        logic        t;
        logic [31:0] value;
        int          idx;
        logic        in_range;
        t_best       prior;
        t_best       now;
        t_winner     res;
        t        = item.target;
        value    = (t == TBL_OFFSET) ? {16'h0000, item.value[15:0]} : item.value;
        idx      = int'(item.idx);
        in_range = idx < POLICY_COUNT;
        now      = stored_best[t];
        if (item.mode == MODE_COMMIT && in_range) begin
            prior                  = stored_best[t];
            entry_value[t][idx]    = value;
            entry_ok[t][idx]       = item.ok;
            entry_present[t][idx]  = 1'b1;
            now                    = lowest_valid(t, 1'b0, 0, '0, 1'b0);
            stored_best[t]         = now;
            changed_flag[t]        = (prior != now);
        end else if (item.mode == MODE_REMOVE && in_range) begin
            if (entry_present[t][idx]) begin
                prior               = stored_best[t];
                entry_value[t][idx] = '0;
                entry_ok[t][idx]    = 1'b0;
                now                 = lowest_valid(t, 1'b0, 0, '0, 1'b0);
                stored_best[t]      = now;
                if (t == TBL_VOLT)
                    changed_flag[t] = (prior != now);
                else
                    changed_flag[t] = now.valid && (prior != now);
            end else begin
                changed_flag[t] = 1'b0;
            end
        end else if (item.mode == MODE_PREVIEW || item.mode == MODE_UNUSED) begin
            now = lowest_valid(t, in_range, idx, value, item.ok);
        end
        res.valid   = now.valid;
        res.value   = now.value;
        res.changed = changed_flag[t];
        return res;
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom_range(0, 15);
            3:       v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'(
                         $urandom_range(0, 15))};
            4, 5, 6: v = $urandom;
            default: v = {16'($urandom), 8'h00, 8'($urandom_range(0, 255))};
        endcase
        return v;
    endfunction

    function automatic t_req_item random_request();
        t_req_item item;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            item.mode = MODE_COMMIT;
        else if (pick < 65)
            item.mode = MODE_REMOVE;
        else if (pick < 95)
            item.mode = MODE_PREVIEW;
        else
            item.mode = MODE_UNUSED;
        item.target = $urandom_range(0, 1) ? TBL_OFFSET : TBL_VOLT;
        item.idx    = 4'($urandom_range(0, 15));
        item.value  = random_value();
        item.ok     = ($urandom_range(0, 4) != 0);
        return item;
    endfunction

    // Bursts of requests presented without a pause, with random gaps between bursts
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                req_if.valid         <= 1'b0;
                req_if.mode          <= 2'($urandom);
                req_if.target        <= 1'($urandom);
                req_if.policy_index  <= 4'($urandom);
                req_if.request_value <= $urandom;
                req_if.request_valid <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Present one request, wait for its transfer, record the expected winner
    task automatic send_request(input t_req_item item, input logic has_exp,
                                input t_winner exp);
        t_winner predicted;
        req_if.valid         <= 1'b1;
        req_if.mode          <= item.mode;
        req_if.target        <= item.target;
        req_if.policy_index  <= item.idx;
        req_if.request_value <= item.value;
        req_if.request_valid <= item.ok;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = arbitrate_item(item);
        pending_winners.push_back(has_exp ? exp : predicted);
    endtask

    // Stimulus and end of run
    initial begin
        int n;
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.mode          <= MODE_PREVIEW;
        req_if.target        <= TBL_VOLT;
        req_if.policy_index  <= '0;
        req_if.request_value <= '0;
        req_if.request_valid <= 1'b0;
        error_count    = 0;
        mismatch_count = 0;
        burst_left     = 0;
        clear_tables();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < STIM_ROWS; n++) begin
            pace_sender();
            send_request(STIM_TABLE[n].item, STIM_TABLE[n].has_exp, STIM_TABLE[n].exp);
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pace_sender();
            send_request(random_request(), 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_winners.size() != 0) @(posedge i_clk);
        repeat (4 * ITEM_LATENCY) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result stalls: phases of steady, random, periodic and long-withheld ready
    initial begin
        int phase_left;
        int kind;
        int period;
        int tick;
        phase_left = 0;
        kind       = 0;
        period     = 1;
        tick       = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_left == 0) begin
                kind       = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 120);
                period     = $urandom_range(2, 7);
            end
            phase_left--;
            tick++;
            case (kind)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= 1'($urandom_range(0, 1));
                2:       res_if.ready <= ((tick % period) == 0);
                default: res_if.ready <= (phase_left < 10);
            endcase
        end
    end

    // Compare each result transfer with the oldest expected winner
    always @(posedge i_clk) begin
        t_winner exp;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_winners.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result valid=%0b value=%h changed=%0b",
                             $realtime, res_if.winner_valid, res_if.winner_value,
                             res_if.winner_changed);
            end else begin
                exp = pending_winners.pop_front();
                if (res_if.winner_valid !== exp.valid ||
                    res_if.winner_value !== exp.value ||
                    res_if.winner_changed !== exp.changed) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: result mismatch: expected valid=%0b value=%h ",
                                  "changed=%0b, got valid=%0b value=%h changed=%0b"},
                                 $realtime, exp.valid, exp.value, exp.changed,
                                 res_if.winner_valid, res_if.winner_value,
                                 res_if.winner_changed);
                end
            end
        end
    end

endmodule
